// ===== hdl/lz_flag_run_decompressor_top_defines.svh =====
// Assertion macros for the LZ flag-run decompressor.
// Used by lz_flag_run_decompressor_top.sv; expects clk and rst_n in scope.
`ifndef LZ_FLAG_RUN_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ_FLAG_RUN_DECOMPRESSOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lzfd_pkg.sv =====
// Shared constants and types for the LZ flag-run decompressor.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package lzfd_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 4096;
    localparam int unsigned BYTES_PER_RESULT = 4;
    localparam int unsigned CHUNK = (BYTES_PER_RESULT < 4) ? BYTES_PER_RESULT : 4;
    localparam int unsigned ABS_LIMIT        = 4092;
    localparam int unsigned TOKENS_PER_FLAG  = 8;

    localparam int unsigned POS_W  = 24;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 3;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned TOK_W  = 4;

    typedef logic [BYTE_W-1:0] octet_t;
    typedef logic [POS_W-1:0]  pos_t;

endpackage

// ===== hdl/lzfd_in_if.sv =====
// Input request channel of the LZ flag-run decompressor.
// Depends on lzfd_pkg for the field types.
`timescale 1ns / 1ps

interface lzfd_in_if;
    logic               valid;
    logic               ready;
    lzfd_pkg::octet_t   data_byte;
    logic               stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

// ===== hdl/lzfd_out_if.sv =====
// Result channel of the LZ flag-run decompressor.
// Depends on lzfd_pkg for the field widths.
`timescale 1ns / 1ps

interface lzfd_out_if;
    logic                              valid;
    logic                              ready;
    lzfd_pkg::octet_t                  byte_zero;
    lzfd_pkg::octet_t                  byte_one;
    lzfd_pkg::octet_t                  byte_two;
    lzfd_pkg::octet_t                  byte_three;
    logic [lzfd_pkg::CNT_W-1:0]        byte_count;
    logic                              last_of_run;
    logic                              stream_done;
    logic                              bad_offset;

    modport source (output valid, output byte_zero, output byte_one, output byte_two,
                    output byte_three, output byte_count, output last_of_run,
                    output stream_done, output bad_offset, input ready);
    modport sink   (input valid, input byte_zero, input byte_one, input byte_two,
                    input byte_three, input byte_count, input last_of_run,
                    input stream_done, input bad_offset, output ready);
endinterface

// ===== hdl/lzfd_cfg_if.sv =====
// Configuration write channel carrying the output length register.
// Depends on lzfd_pkg for the register width.
`timescale 1ns / 1ps

interface lzfd_cfg_if;
    logic               valid;
    logic               ready;
    lzfd_pkg::pos_t     output_length;

    modport source (output valid, output output_length, input ready);
    modport sink   (input valid, input output_length, output ready);
endinterface

// ===== hdl/lz_flag_run_decompressor_top.sv =====
// LZ flag-run decompressor: parser, history window memory and copy engine.
// Depends on lzfd_pkg, the three channel interfaces and the assertion macro header.
//
// Usage: compressed bytes arrive one request at a time on in_ch (valid/ready).
// Flag, count and offset bytes give no result; a literal byte gives one result
// of one byte. A match count byte starts a copy that produces results of up to
// four bytes on out_ch, the last one marked by last_of_run; a bad offset gives a
// single result with byte_count 0 and bad_offset set. The output length is
// written on cfg, which is always ready, and must only change while idle.
// A literal byte's result is registered on out_ch in the cycle after the request is
// taken. A match keeps in_ch not ready until its copy is done: the window memory
// has one read and one write port, so the copy moves one byte per cycle behind a
// registered read while the receiver takes its results.
// If the receiver stalls, the copy pauses with its pending byte held, and no new
// request is taken while a result is waiting and cannot move on.
// Reset clears the parser, the position and the length; the window memory is not
// cleared, as only bytes written in the current stream are ever read.
`timescale 1ns / 1ps
`include "lz_flag_run_decompressor_top_defines.svh"

module lz_flag_run_decompressor_top #(
    parameter int unsigned WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    lzfd_in_if.sink          in_ch,
    lzfd_out_if.source       out_ch,
    lzfd_cfg_if.sink         cfg
);

    localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
    localparam int unsigned CHUNK = lzfd_pkg::CHUNK;
    localparam int unsigned KW    = $clog2(CHUNK);
    localparam int unsigned POS_W = lzfd_pkg::POS_W;
    localparam int unsigned CNT_W = lzfd_pkg::CNT_W;
    localparam int unsigned TOK_W = lzfd_pkg::TOK_W;
    localparam int unsigned OFF_W = lzfd_pkg::OFF_W;

    localparam logic [2:0] PH_FLAG        = 3'd0;
    localparam logic [2:0] PH_LIT_COUNT   = 3'd1;
    localparam logic [2:0] PH_LIT_DATA    = 3'd2;
    localparam logic [2:0] PH_OFF_LO      = 3'd3;
    localparam logic [2:0] PH_OFF_HI      = 3'd4;
    localparam logic [2:0] PH_MATCH_COUNT = 3'd5;

    // Control state.
    lzfd_pkg::pos_t      len_reg, len_next;
    lzfd_pkg::pos_t      pos_reg, pos_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [2:0]          phase_reg, phase_next;
    lzfd_pkg::octet_t    flags_reg, flags_next;
    logic [TOK_W-1:0]    tokens_reg, tokens_next;
    lzfd_pkg::octet_t    off_lo_reg, off_lo_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    lzfd_pkg::octet_t    lit_reg, lit_next;
    logic [AW-1:0]       src_ptr_reg, src_ptr_next;
    lzfd_pkg::octet_t    issue_left_reg, issue_left_next;
    lzfd_pkg::octet_t    absorb_left_reg, absorb_left_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                out_valid_reg, out_valid_next;

    // Payload state.
    lzfd_pkg::octet_t    buf_reg [CHUNK-1];
    lzfd_pkg::octet_t    buf_next [CHUNK-1];
    lzfd_pkg::octet_t    out_b_reg [4];
    lzfd_pkg::octet_t    out_b_next [4];
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;
    logic                out_done_reg, out_done_next;
    logic                out_bad_reg, out_bad_next;

    // History window and its read path.
    lzfd_pkg::octet_t    window_mem [WINDOW_DEPTH];
    lzfd_pkg::octet_t    mem_q_reg;
    logic                fwd_hit_reg;
    lzfd_pkg::octet_t    fwd_data_reg;
    logic                we;
    logic [AW-1:0]       waddr;
    lzfd_pkg::octet_t    wdata;
    logic                rd_en;
    logic [AW-1:0]       raddr;
    lzfd_pkg::octet_t    rd_data;

    // Handshake and per-request working values.
    logic                in_ready;
    logic                in_fire;
    logic                out_free;
    logic                busy;
    logic                chunk_end;
    logic                absorb;
    lzfd_pkg::octet_t    b;
    lzfd_pkg::pos_t      e_pos;
    logic [AW-1:0]       e_wr_ptr;
    logic [2:0]          e_phase;
    lzfd_pkg::octet_t    e_flags;
    logic [TOK_W-1:0]    e_tokens;
    lzfd_pkg::octet_t    e_off_lo;
    logic [OFF_W-1:0]    e_off;
    lzfd_pkg::octet_t    e_lit;
    lzfd_pkg::octet_t    et_flags;
    logic [TOK_W-1:0]    et_tokens;
    logic [2:0]          et_phase;
    lzfd_pkg::octet_t    lit_dec;
    logic                abs_mode;
    logic                bad;
    logic [AW:0]         dist_src;
    logic [AW-1:0]       start_src;
    lzfd_pkg::pos_t      remain;
    lzfd_pkg::octet_t    run_len;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    assign busy     = rd_pend_reg || (absorb_left_reg != '0);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ready = !busy && out_free;
    assign in_fire  = in_ch.valid && in_ready;
    assign rd_data  = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    assign chunk_end = (k_reg == KW'(CHUNK - 1)) || (absorb_left_reg == 8'd1);
    assign absorb    = rd_pend_reg && (!chunk_end || out_free);

    // Values after an optional stream restart, then the end-of-token update.
    always_comb
    begin
        b        = in_ch.data_byte;
        e_pos    = in_ch.stream_start ? '0 : pos_reg;
        e_wr_ptr = in_ch.stream_start ? '0 : wr_ptr_reg;
        e_phase  = in_ch.stream_start ? PH_FLAG : phase_reg;
        e_flags  = in_ch.stream_start ? '0 : flags_reg;
        e_tokens = in_ch.stream_start ? '0 : tokens_reg;
        e_off_lo = in_ch.stream_start ? '0 : off_lo_reg;
        e_off    = in_ch.stream_start ? '0 : off_reg;
        e_lit    = in_ch.stream_start ? '0 : lit_reg;

        et_flags  = e_flags >> 1;
        et_tokens = e_tokens - TOK_W'(1);
        if (et_tokens == '0)
        begin
            et_phase = PH_FLAG;
        end
        else
        begin
            et_phase = et_flags[0] ? PH_OFF_LO : PH_LIT_COUNT;
        end
        lit_dec = e_lit - 8'd1;

        abs_mode = (e_pos < POS_W'(lzfd_pkg::ABS_LIMIT));
        if (abs_mode)
        begin
            bad = (POS_W'(e_off) >= e_pos);
        end
        else
        begin
            bad = (e_off >= OFF_W'(lzfd_pkg::ABS_LIMIT));
        end
        dist_src = (AW + 1)'(e_wr_ptr) - (AW + 1)'(12'(lzfd_pkg::ABS_LIMIT) - e_off[11:0]);
        if (abs_mode)
        begin
            start_src = AW'(e_off);
        end
        else if (dist_src[AW])
        begin
            start_src = AW'(dist_src + (AW + 1)'(WINDOW_DEPTH));
        end
        else
        begin
            start_src = dist_src[AW-1:0];
        end
        remain  = len_reg - e_pos;
        run_len = (remain < POS_W'(b)) ? remain[7:0] : b;
    end

    always_comb
    begin
        len_next         = len_reg;
        pos_next         = pos_reg;
        wr_ptr_next      = wr_ptr_reg;
        phase_next       = phase_reg;
        flags_next       = flags_reg;
        tokens_next      = tokens_reg;
        off_lo_next      = off_lo_reg;
        off_next         = off_reg;
        lit_next         = lit_reg;
        src_ptr_next     = src_ptr_reg;
        issue_left_next  = issue_left_reg;
        absorb_left_next = absorb_left_reg;
        rd_pend_next     = rd_pend_reg;
        k_next           = k_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        buf_next         = buf_reg;
        out_b_next       = out_b_reg;
        out_cnt_next     = out_cnt_reg;
        out_last_next    = out_last_reg;
        out_done_next    = out_done_reg;
        out_bad_next     = out_bad_reg;
        we               = 1'b0;
        waddr            = wr_ptr_reg;
        wdata            = '0;
        rd_en            = 1'b0;
        raddr            = src_ptr_reg;

        if (cfg.valid)
        begin
            len_next = cfg.output_length;
        end

        // Copy engine: take the pending byte read from the window into the window and the result.
        if (absorb)
        begin
            we               = 1'b1;
            wdata            = rd_data;
            wr_ptr_next      = ptr_inc(wr_ptr_reg);
            pos_next         = pos_reg + POS_W'(1);
            absorb_left_next = absorb_left_reg - 8'd1;
            rd_pend_next     = 1'b0;
            if (chunk_end)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    out_b_next[i] = '0;
                end
                for (int i = 0; i < CHUNK - 1; i++)
                begin
                    if (KW'(i) < k_reg)
                    begin
                        out_b_next[i] = buf_reg[i];
                    end
                end
                for (int i = 0; i < CHUNK; i++)
                begin
                    if (KW'(i) == k_reg)
                    begin
                        out_b_next[i] = rd_data;
                    end
                end
                out_cnt_next   = CNT_W'(k_reg) + CNT_W'(1);
                out_last_next  = (absorb_left_reg == 8'd1);
                out_done_next  = (pos_reg + POS_W'(1) >= len_reg);
                out_bad_next   = 1'b0;
                out_valid_next = 1'b1;
                k_next         = '0;
            end
            else
            begin
                buf_next[k_reg] = rd_data;
                k_next          = k_reg + KW'(1);
            end
        end

        if ((issue_left_reg != '0) && (!rd_pend_reg || absorb))
        begin
            rd_en           = 1'b1;
            rd_pend_next    = 1'b1;
            src_ptr_next    = ptr_inc(src_ptr_reg);
            issue_left_next = issue_left_reg - 8'd1;
        end

        // Parser: one compressed byte per request.
        if (in_fire)
        begin
            pos_next    = e_pos;
            wr_ptr_next = e_wr_ptr;
            phase_next  = e_phase;
            flags_next  = e_flags;
            tokens_next = e_tokens;
            off_lo_next = e_off_lo;
            off_next    = e_off;
            lit_next    = e_lit;
            if (e_pos < len_reg)
            begin
                unique case (e_phase)
                    PH_FLAG:
                    begin
                        flags_next  = b;
                        tokens_next = TOK_W'(lzfd_pkg::TOKENS_PER_FLAG);
                        phase_next  = b[0] ? PH_OFF_LO : PH_LIT_COUNT;
                    end
                    PH_LIT_COUNT:
                    begin
                        lit_next = b;
                        if (b == '0)
                        begin
                            flags_next  = et_flags;
                            tokens_next = et_tokens;
                            phase_next  = et_phase;
                        end
                        else
                        begin
                            phase_next = PH_LIT_DATA;
                        end
                    end
                    PH_LIT_DATA:
                    begin
                        we          = 1'b1;
                        waddr       = e_wr_ptr;
                        wdata       = b;
                        wr_ptr_next = ptr_inc(e_wr_ptr);
                        pos_next    = e_pos + POS_W'(1);
                        lit_next    = lit_dec;
                        if (lit_dec == '0)
                        begin
                            flags_next  = et_flags;
                            tokens_next = et_tokens;
                            phase_next  = et_phase;
                        end
                        for (int i = 0; i < 4; i++)
                        begin
                            out_b_next[i] = '0;
                        end
                        out_b_next[0]  = b;
                        out_cnt_next   = CNT_W'(1);
                        out_last_next  = 1'b1;
                        out_done_next  = (e_pos + POS_W'(1) >= len_reg);
                        out_bad_next   = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    PH_OFF_LO:
                    begin
                        off_lo_next = b;
                        phase_next  = PH_OFF_HI;
                    end
                    PH_OFF_HI:
                    begin
                        off_next   = {b, e_off_lo};
                        phase_next = PH_MATCH_COUNT;
                    end
                    PH_MATCH_COUNT:
                    begin
                        flags_next  = et_flags;
                        tokens_next = et_tokens;
                        phase_next  = et_phase;
                        if (b != '0)
                        begin
                            if (bad)
                            begin
                                for (int i = 0; i < 4; i++)
                                begin
                                    out_b_next[i] = '0;
                                end
                                out_cnt_next   = '0;
                                out_last_next  = 1'b1;
                                out_done_next  = (e_pos >= len_reg);
                                out_bad_next   = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                src_ptr_next     = start_src;
                                issue_left_next  = run_len;
                                absorb_left_next = run_len;
                                k_next           = '0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_FLAG;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            pos_reg         <= '0;
            wr_ptr_reg      <= '0;
            phase_reg       <= PH_FLAG;
            flags_reg       <= '0;
            tokens_reg      <= '0;
            off_lo_reg      <= '0;
            off_reg         <= '0;
            lit_reg         <= '0;
            src_ptr_reg     <= '0;
            issue_left_reg  <= '0;
            absorb_left_reg <= '0;
            rd_pend_reg     <= 1'b0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg         <= len_next;
            pos_reg         <= pos_next;
            wr_ptr_reg      <= wr_ptr_next;
            phase_reg       <= phase_next;
            flags_reg       <= flags_next;
            tokens_reg      <= tokens_next;
            off_lo_reg      <= off_lo_next;
            off_reg         <= off_next;
            lit_reg         <= lit_next;
            src_ptr_reg     <= src_ptr_next;
            issue_left_reg  <= issue_left_next;
            absorb_left_reg <= absorb_left_next;
            rd_pend_reg     <= rd_pend_next;
            k_reg           <= k_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        out_b_reg    <= out_b_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_bad_reg  <= out_bad_next;
    end

    // Window memory. A read of the entry being written in the same cycle takes the new byte.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            window_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            mem_q_reg    <= window_mem[raddr];
            fwd_hit_reg  <= we && (waddr == raddr);
            fwd_data_reg <= wdata;
        end
    end

    assign in_ch.ready        = in_ready;
    assign cfg.ready          = 1'b1;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.byte_zero   = out_b_reg[0];
    assign out_ch.byte_one    = out_b_reg[1];
    assign out_ch.byte_two    = out_b_reg[2];
    assign out_ch.byte_three  = out_b_reg[3];
    assign out_ch.byte_count  = out_cnt_reg;
    assign out_ch.last_of_run = out_last_reg;
    assign out_ch.stream_done = out_done_reg;
    assign out_ch.bad_offset  = out_bad_reg;

    `LZFD_ASSERT_SAME(a_empty_result_is_error, out_valid_reg, (out_cnt_reg == '0) == out_bad_reg, "result with no bytes must be an error result")
    `LZFD_ASSERT_SAME(a_copy_counts_agree, 1'b1, absorb_left_reg == issue_left_reg + 8'(rd_pend_reg), "copy read and write counters disagree")
    `LZFD_ASSERT_SAME(a_copy_within_length, absorb_left_reg != '0, 25'(pos_reg) + 25'(absorb_left_reg) <= 25'(len_reg), "copy runs past the output length")
    `LZFD_ASSERT_NEXT(a_held_byte_stable, rd_pend_reg && !absorb, rd_pend_reg && $stable(rd_data), "held copy byte changed while stalled")

endmodule
